// ===== hw/rtl/index_edge_revolution_calibrator_defines.svh =====
// Assertion macros shared by the calibrator RTL.
// No dependencies; taken in by `include where checks are written.
`ifndef INDEX_EDGE_REVOLUTION_CALIBRATOR_DEFINES_SVH
`define INDEX_EDGE_REVOLUTION_CALIBRATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Check that is ignored while reset is high
`define IERC_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
// Check that also covers the reset cycles
`define IERC_ASSERT_ALL(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define IERC_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define IERC_ASSERT_ALL(lbl, clk_sig, prop, msg)
`endif
`endif

// ===== hw/rtl/iercal_pkg.sv =====
// Shared types and constants of the index edge revolution calibrator.
// No dependencies; used by iercal_tracker and the top level.
package iercal_pkg;

  // Item kinds carried on the input tuser bit
  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  // Edge counting
  localparam logic [2:0] EdgesNeeded       = 3'd4;
  localparam logic [2:0] FirstIntervalEdge = 3'd2;
  localparam logic [2:0] EdgeCountMax      = 3'd7;

  // Counter limits
  localparam logic [16:0] StepCountMax = 17'h1FFFF;
  localparam logic [15:0] MaxStepsReset = 16'd16384;

  // Division by three of an 18-bit sum: floor(x * 174763 / 2^19)
  localparam logic [17:0] Div3Mult  = 18'd174763;
  localparam int          Div3Shift = 19;

  // Calibration status as seen after the latest item
  typedef struct packed {
    logic        finished;
    logic        success;
    logic [2:0]  edges;
    logic [17:0] interval_sum;
  } status_t;

endpackage

// ===== hw/rtl/iercal_tracker.sv =====
// Calibration state: edge detection, step and interval counters, limit check.
// Depends on iercal_pkg.
module iercal_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 action,
  input  logic                 level,
  input  logic [15:0]          max_steps,
  output iercal_pkg::status_t  status
);

  logic        last_level;
  logic [16:0] step_total;
  logic [2:0]  edge_total;
  logic        seen_first_edge;
  logic [16:0] interval_steps;
  logic [17:0] interval_sum;
  logic        finished;

  logic        last_level_next;
  logic [16:0] step_total_next;
  logic [2:0]  edge_total_next;
  logic        seen_first_edge_next;
  logic [16:0] interval_steps_next;
  logic [17:0] interval_sum_next;
  logic        finished_next;

  // Next state for one item
  always_comb begin
    last_level_next      = last_level;
    step_total_next      = step_total;
    edge_total_next      = edge_total;
    seen_first_edge_next = seen_first_edge;
    interval_steps_next  = interval_steps;
    interval_sum_next    = interval_sum;
    finished_next        = finished;
    if (action == iercal_pkg::ActStart) begin
      last_level_next      = level;
      step_total_next      = '0;
      edge_total_next      = '0;
      seen_first_edge_next = 1'b0;
      interval_steps_next  = '0;
      interval_sum_next    = '0;
      finished_next        = 1'b0;
    end else if (!finished) begin
      if (step_total < iercal_pkg::StepCountMax) begin
        step_total_next = step_total + 17'd1;
      end
      if (seen_first_edge && (interval_steps < iercal_pkg::StepCountMax)) begin
        interval_steps_next = interval_steps + 17'd1;
      end
      // Falling edge on the index sensor
      if (last_level && !level) begin
        if (edge_total < iercal_pkg::EdgeCountMax) begin
          edge_total_next = edge_total + 3'd1;
        end
        if (!seen_first_edge) begin
          seen_first_edge_next = 1'b1;
        end else begin
          if ((edge_total_next >= iercal_pkg::FirstIntervalEdge) &&
              (edge_total_next <= iercal_pkg::EdgesNeeded)) begin
            interval_sum_next = interval_sum + {1'b0, interval_steps_next};
          end
          interval_steps_next = '0;
        end
      end
      if ((edge_total_next >= iercal_pkg::EdgesNeeded) ||
          (step_total_next > {1'b0, max_steps})) begin
        finished_next = 1'b1;
      end
      last_level_next = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level      <= 1'b0;
      step_total      <= '0;
      edge_total      <= '0;
      seen_first_edge <= 1'b0;
      interval_steps  <= '0;
      interval_sum    <= '0;
      finished        <= 1'b0;
    end else if (load) begin
      last_level      <= last_level_next;
      step_total      <= step_total_next;
      edge_total      <= edge_total_next;
      seen_first_edge <= seen_first_edge_next;
      interval_steps  <= interval_steps_next;
      interval_sum    <= interval_sum_next;
      finished        <= finished_next;
    end
  end

  // Status after the latest item
  assign status.finished     = finished;
  assign status.success      = finished && (edge_total >= iercal_pkg::EdgesNeeded);
  assign status.edges        = edge_total;
  assign status.interval_sum = interval_sum;

endmodule

// ===== hw/rtl/index_edge_revolution_calibrator.sv =====
// Top level of the index edge revolution calibrator: handshakes, pipeline, averaging.
// Depends on iercal_pkg, iercal_tracker and index_edge_revolution_calibrator_defines.svh.
//
//  channel   direction  signals                         content
//  s_*       in         s_tvalid s_tready s_tuser s_tdata  action, sensor level
//  m_*       out        m_tvalid m_tready m_tdata          one result per input
//  cfg_*     in         cfg_valid cfg_ready cfg_data       max_steps register
//
// Three stages: input register, state update, output register with divide by three.
// One item per cycle sustained unless m_tready stalls the pipeline.
// rst clears the pipeline, all counts and sets max_steps to 16384.
// A stalled m_tready fills the stages in turn; s_tready falls once all three are full.
// cfg_ready is always high; user must write while no item is in flight, not enforced.
`include "index_edge_revolution_calibrator_defines.svh"

module index_edge_revolution_calibrator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // [0] action
  input  logic [7:0]  s_tdata,   // [0] sensor_level, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] done_res, [1] success, [4:2] edges_seen,
                                 // [20:5] rev_steps, [23:21] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        a_valid;
  logic        a_action;
  logic        a_level;
  logic        a_ready;
  logic        b_valid;
  logic        b_ready;
  logic        c_ready;
  logic [15:0] max_steps;

  iercal_pkg::status_t status;

  logic [35:0] avg_product;
  logic [16:0] avg_quot;
  logic [15:0] avg_sat;
  logic [15:0] rev_steps;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps <= iercal_pkg::MaxStepsReset;
    end else if (cfg_valid && cfg_ready) begin
      max_steps <= cfg_data;
    end
  end

  // Stage readiness
  assign c_ready  = !m_tvalid || m_tready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && a_ready) begin
      a_action <= s_tuser;
      a_level  <= s_tdata[0];
    end
  end

  // State update stage; the tracker registers hold this stage's payload
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  iercal_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .load      (a_valid && b_ready),
    .action    (a_action),
    .level     (a_level),
    .max_steps (max_steps),
    .status    (status)
  );

  // Average of three intervals, saturated to 16 bits
  assign avg_product = 36'(status.interval_sum) * 36'(iercal_pkg::Div3Mult);
  assign avg_quot    = avg_product[iercal_pkg::Div3Shift +: 17];
  assign avg_sat     = avg_quot[16] ? 16'hFFFF : avg_quot[15:0];
  assign rev_steps   = status.success ? avg_sat : 16'd0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (c_ready) begin
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_ready) begin
      m_tdata <= {3'b000, rev_steps, status.edges, status.success, status.finished};
    end
  end

  // Checks
  `IERC_ASSERT_ALL(a_reset_clears_out, clk, rst |=> !m_tvalid, "output valid after reset")
  `IERC_ASSERT(a_success_needs_edges, clk, rst,
    status.success |-> (status.finished && (status.edges == iercal_pkg::EdgesNeeded)),
    "success without four edges")
  `IERC_ASSERT(a_edges_bounded, clk, rst, status.edges <= iercal_pkg::EdgesNeeded,
    "edge count beyond four")
  `IERC_ASSERT(a_fail_zero_steps, clk, rst,
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[20:5] == 16'd0),
    "nonzero step count without success")
  `IERC_ASSERT(a_stall_only_full, clk, rst, !s_tready |-> (a_valid && b_valid && m_tvalid),
    "input stalled with a free stage")

endmodule
